// File: rtl/frame_pacing_timer_core_assert.svh
// ----------------------------------------------------------------------------
// frame pacing timer assertion macros
// shared property templates for the frame pacing timer rtl
// ----------------------------------------------------------------------------
`ifndef FRAME_PACING_TIMER_CORE_ASSERT_SVH
`define FRAME_PACING_TIMER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FPT_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FPT_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_pkg
// types and constants shared by the frame pacing timer modules
// ----------------------------------------------------------------------------
package fpt_pkg;

    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int DELTA_W  = 40;
    localparam int RATE_W   = 32;
    localparam int WAIT_W   = 32;

    // 23*old + 2*inst fits in this many bits
    localparam int EMA_SUM_W = 38;

    localparam logic [TIME_W-1:0] NS_PER_SEC = 64'd1000000000;
    localparam logic [TIME_W-1:0] EMA_DIVISOR = 64'd25;

    // divide by 25 one byte per step: remainder below 25 joined with the next byte
    localparam int EMA_DIGIT_W = 8;
    localparam int EMA_STEPS   = 5;
    localparam int EMA_DIV_W   = EMA_DIGIT_W * EMA_STEPS;
    localparam int EMA_REM_W   = 5;
    localparam int EMA_PART_W  = EMA_REM_W + EMA_DIGIT_W;
    localparam int EMA_CNT_W   = $clog2(EMA_STEPS);

    // floor(v / 25) = (v * 5243) >> 17 for every v below 25 * 256
    localparam logic [EMA_PART_W-1:0] EMA_RECIP = 13'd5243;
    localparam int EMA_RECIP_SHIFT = 17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCHED2,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_EMA_SUM,
        ST_EMA_DIV,
        ST_DONE
    } fpt_state_t;

    typedef struct packed {
        logic load_in;
        logic first;
        logic sched1;
        logic sched2;
        logic div_start;
        logic ema_sum;
        logic ema_step;
        logic ema_done;
        logic out_load;
    } fpt_cmd_t;

    typedef struct packed {
        logic armed;
        logic avg_zero;
        logic div_done;
        logic ema_last;
    } fpt_status_t;

endpackage

// File: rtl/fpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt channel interfaces
// valid/ready channels for frame-end events and pacing results
// ----------------------------------------------------------------------------
interface fpt_in_if
    import fpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output now_time, input ready);
    modport sink   (input valid, input now_time, output ready);
endinterface

interface fpt_out_if
    import fpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WAIT_W-1:0]  wait_time;
    logic [DELTA_W-1:0] frame_delta;
    logic [RATE_W-1:0]  smoothed_rate;

    modport source (output valid, output wait_time, output frame_delta,
                    output smoothed_rate, input ready);
    modport sink   (input valid, input wait_time, input frame_delta,
                    input smoothed_rate, output ready);
endinterface

// File: rtl/fpt_div.sv
`timescale 1ns / 1ps
`include "frame_pacing_timer_core_assert.svh"
// ----------------------------------------------------------------------------
// fpt_div
// restoring bit-serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fpt_div
    import fpt_pkg::*;
#(
    parameter int DW = 46
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [DW-1:0]     quotient
);

    localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;

    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   trial_sub;
    logic              fits;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, restore when it does not fit
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `FPT_ASSERT_IMP(a_start_when_idle, clk, rst_n, start, !busy_reg && !done_reg, "divider restarted while busy")
    `FPT_ASSERT_NXT(a_done_ends_busy, clk, rst_n, busy_reg && cnt_reg == CNT_W'(DW - 1), done_reg && !busy_reg, "divider did not finish after last step")

endmodule

// File: rtl/fpt_ctrl.sv
`timescale 1ns / 1ps
`include "frame_pacing_timer_core_assert.svh"
// ----------------------------------------------------------------------------
// fpt_ctrl
// sequencer for one frame-end item and the output handshake
// ----------------------------------------------------------------------------
module fpt_ctrl
    import fpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  fpt_status_t status,
    output fpt_cmd_t    cmd
);

    fpt_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_CHECK;
            ST_CHECK:      state_next = status.armed ? ST_SCHED2 : ST_DONE;
            ST_SCHED2:     state_next = ST_RATE_START;
            ST_RATE_START: state_next = ST_RATE_WAIT;
            ST_RATE_WAIT:  if (status.div_done) state_next = ST_EMA_SUM;
            ST_EMA_SUM:    state_next = status.avg_zero ? ST_DONE : ST_EMA_DIV;
            ST_EMA_DIV:    if (status.ema_last) state_next = ST_DONE;
            ST_DONE:       if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_CHECK:
            begin
                cmd.first  = !status.armed;
                cmd.sched1 = status.armed;
            end
            ST_SCHED2:     cmd.sched2 = 1'b1;
            ST_RATE_START: cmd.div_start = 1'b1;
            ST_RATE_WAIT:  cmd = '0;
            ST_EMA_SUM:    cmd.ema_sum = 1'b1;
            ST_EMA_DIV:
            begin
                cmd.ema_step = 1'b1;
                cmd.ema_done = status.ema_last;
            end
            ST_DONE:       cmd.out_load = !out_valid_reg || out_ready;
            default:       cmd = '0;
        endcase
    end

    // output slot stays full until taken, refilled on the same edge if needed
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `FPT_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "pending result overwritten")
    `FPT_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg && state_reg == ST_IDLE, "loaded result not presented")

endmodule

// File: rtl/fpt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_datapath
// schedule state, frame delta, rate division and smoothing registers
// ----------------------------------------------------------------------------
module fpt_datapath
    import fpt_pkg::*;
#(
    parameter int RATE_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    input  logic [TIME_W-1:0]   now_time,
    input  fpt_cmd_t            cmd,
    output fpt_status_t         status,
    output logic [WAIT_W-1:0]   wait_time,
    output logic [DELTA_W-1:0]  frame_delta,
    output logic [RATE_W-1:0]   smoothed_rate
);

    // 1e9 < 2^30, so the rate dividend needs 30 + frac bits
    localparam int RATE_NUM_W = 30 + RATE_FRAC_BITS;
    localparam int DW = RATE_NUM_W;
    localparam logic [DW-1:0] RATE_NUM = DW'(NS_PER_SEC) << RATE_FRAC_BITS;

    logic [PERIOD_W-1:0]  period_reg;
    logic                 armed_reg;
    logic [TIME_W-1:0]    last_end_reg;
    logic [TIME_W-1:0]    deadline_reg;
    logic [RATE_W-1:0]    avg_reg;

    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    end_reg;
    logic [TIME_W-1:0]    dl_adv_reg;
    logic [TIME_W-1:0]    delta_reg;
    logic [WAIT_W-1:0]    wait_reg;
    logic [EMA_DIV_W-1:0] sum_reg;
    logic [EMA_REM_W-1:0] ema_rem_reg;
    logic [RATE_W-1:0]    ema_quo_reg;
    logic [EMA_CNT_W-1:0] ema_cnt_reg;

    logic [WAIT_W-1:0]    out_wait_reg;
    logic [DELTA_W-1:0]   out_delta_reg;
    logic [RATE_W-1:0]    out_rate_reg;

    logic [TIME_W-1:0]    period_ext;
    logic                 period_on;
    logic                 early;
    logic [TIME_W-1:0]    wait_full;
    logic [WAIT_W-1:0]    wait_calc;
    logic [TIME_W-1:0]    end_calc;
    logic [TIME_W-1:0]    dl_adv_calc;
    logic [TIME_W-1:0]    dl_resync;
    logic [TIME_W-1:0]    dl_next;
    logic [TIME_W-1:0]    delta_calc;
    logic                 delta_zero;
    logic [RATE_W-1:0]    inst_val;
    logic [EMA_SUM_W-1:0] sum_calc;
    logic [DELTA_W-1:0]   delta_sat;

    logic [EMA_PART_W-1:0]   ema_part;
    logic [2*EMA_PART_W-1:0] ema_prod;
    logic [EMA_DIGIT_W-1:0]  ema_digit;
    logic [EMA_PART_W-1:0]   ema_rem_full;
    logic [RATE_W-1:0]       ema_quo_calc;
    logic                    ema_last;

    logic                 div_done;
    logic [DW-1:0]        div_quot;

    assign period_ext = {{(TIME_W-PERIOD_W){1'b0}}, period_reg};
    assign period_on  = period_reg != '0;

    // first half of the schedule: wait and frame end
    assign early     = period_on && (now_reg < deadline_reg);
    assign wait_full = deadline_reg - now_reg;
    assign wait_calc = !early ? '0 :
                       (wait_full[TIME_W-1:WAIT_W] != '0) ? '1 : wait_full[WAIT_W-1:0];
    assign end_calc    = early ? deadline_reg : now_reg;
    assign dl_adv_calc = deadline_reg + period_ext;

    // second half: resync when behind, and frame delta
    assign dl_resync  = end_reg + period_ext;
    assign dl_next    = !period_on ? deadline_reg :
                        (dl_adv_reg < end_reg) ? dl_resync : dl_adv_reg;
    assign delta_calc = (end_reg > last_end_reg) ? end_reg - last_end_reg : '0;
    assign delta_zero = delta_reg == '0;

    assign inst_val = delta_zero ? '0 :
                      (div_quot[DW-1:RATE_W] != '0) ? '1 : div_quot[RATE_W-1:0];

    // 23*old + 2*inst = 16*old + 8*old - old + 2*inst
    assign sum_calc = EMA_SUM_W'({avg_reg, 4'b0000}) + EMA_SUM_W'({avg_reg, 3'b000})
                    - EMA_SUM_W'(avg_reg) + EMA_SUM_W'({inst_val, 1'b0});

    // long division of the sum by 25, one quotient byte per step, msb first
    assign ema_part     = {ema_rem_reg, sum_reg[EMA_DIV_W-1 -: EMA_DIGIT_W]};
    assign ema_prod     = {{EMA_PART_W{1'b0}}, ema_part} * {{EMA_PART_W{1'b0}}, EMA_RECIP};
    assign ema_digit    = ema_prod[EMA_RECIP_SHIFT +: EMA_DIGIT_W];
    assign ema_rem_full = ema_part - EMA_PART_W'(ema_digit) * EMA_PART_W'(EMA_DIVISOR);
    assign ema_quo_calc = {ema_quo_reg[RATE_W-EMA_DIGIT_W-1:0], ema_digit};
    assign ema_last     = ema_cnt_reg == EMA_CNT_W'(EMA_STEPS - 1);

    assign delta_sat = (delta_reg[TIME_W-1:DELTA_W] != '0) ? '1 : delta_reg[DELTA_W-1:0];

    fpt_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (RATE_NUM),
        .divisor  (delta_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= '0;
            armed_reg    <= 1'b0;
            last_end_reg <= '0;
            deadline_reg <= '0;
            avg_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
                armed_reg  <= 1'b0;
            end
            if (cmd.first)
            begin
                armed_reg    <= 1'b1;
                last_end_reg <= now_reg;
                deadline_reg <= now_reg + period_ext;
            end
            if (cmd.sched2)
            begin
                deadline_reg <= dl_next;
                last_end_reg <= end_reg;
            end
            if (cmd.ema_sum && avg_reg == '0)
                avg_reg <= inst_val;
            if (cmd.ema_done)
                avg_reg <= ema_quo_calc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            now_reg <= now_time;
        if (cmd.first)
        begin
            wait_reg  <= '0;
            delta_reg <= period_ext;
        end
        if (cmd.sched1)
        begin
            wait_reg   <= wait_calc;
            end_reg    <= end_calc;
            dl_adv_reg <= dl_adv_calc;
        end
        if (cmd.sched2)
            delta_reg <= delta_calc;
        if (cmd.ema_sum)
        begin
            sum_reg     <= EMA_DIV_W'(sum_calc);
            ema_rem_reg <= '0;
            ema_cnt_reg <= '0;
        end
        if (cmd.ema_step)
        begin
            sum_reg     <= {sum_reg[EMA_DIV_W-EMA_DIGIT_W-1:0], {EMA_DIGIT_W{1'b0}}};
            ema_rem_reg <= ema_rem_full[EMA_REM_W-1:0];
            ema_quo_reg <= ema_quo_calc;
            ema_cnt_reg <= ema_cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_wait_reg  <= wait_reg;
            out_delta_reg <= delta_sat;
            out_rate_reg  <= avg_reg;
        end
    end

    assign status.armed    = armed_reg;
    assign status.avg_zero = avg_reg == '0;
    assign status.div_done = div_done;
    assign status.ema_last = ema_last;

    assign wait_time     = out_wait_reg;
    assign frame_delta   = out_delta_reg;
    assign smoothed_rate = out_rate_reg;

endmodule

// File: rtl/frame_pacing_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacing_timer_core
// frame rate limiter with deadline pacing and a smoothed frame rate
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one frame-end item (now_time in ns). out_ch returns one
//   result per item: wait_time, frame_delta and smoothed_rate (unsigned,
//   RATE_FRAC_BITS fraction bits). cfg_wr_en/cfg_wr_data write the target
//   period; write only while the block is idle. a write rearms the schedule.
// steps from accept to out valid:
//   first item after reset or a period write: check, then result
//   smoothed rate still zero: check, schedule, rate division, result
//   otherwise: check, schedule, rate division, /25 blend, result
//   one item is in flight at a time; the next is accepted in the cycle after
//   the result is loaded. the long steps are the bit-serial divider for
//   1e9/delta and the five byte steps of the /25 blend.
// reset clears the schedule, the period and the average; no item is pending.
// a stalled receiver holds the result in the output register; the next item
// is accepted meanwhile and waits in its final step until the slot frees.
// ----------------------------------------------------------------------------
module frame_pacing_timer_core
    import fpt_pkg::*;
#(
    parameter int RATE_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    fpt_in_if.sink              in_ch,
    fpt_out_if.source           out_ch
);

    fpt_cmd_t    cmd;
    fpt_status_t status;
    logic        in_ready;
    logic        out_valid;

    fpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fpt_datapath #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .now_time      (in_ch.now_time),
        .cmd           (cmd),
        .status        (status),
        .wait_time     (out_ch.wait_time),
        .frame_delta   (out_ch.frame_delta),
        .smoothed_rate (out_ch.smoothed_rate)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

endmodule
